@@ hdl/krt_pkg.sv @@
// Shared types and codes for the keyed record table.
package krt_pkg;

   // Operation codes carried in req_tuser.
   localparam logic [2:0] OP_INSERT = 3'd0;
   localparam logic [2:0] OP_LOOKUP = 3'd1;
   localparam logic [2:0] OP_UPDATE = 3'd2;
   localparam logic [2:0] OP_DELETE = 3'd3;
   localparam logic [2:0] OP_FINDMAX = 3'd4;

   // Status codes carried in rsp_tuser.
   localparam logic [2:0] ST_OK = 3'd0;
   localparam logic [2:0] ST_FULL = 3'd1;
   localparam logic [2:0] ST_DUP = 3'd2;
   localparam logic [2:0] ST_MISSING = 3'd3;
   localparam logic [2:0] ST_EMPTY = 3'd4;

   // One stored record.
   typedef struct packed {
      logic signed [31:0] key;
      logic [7:0]         attribute;
      logic [31:0]        amount;
   } rec_type;

   // Which record the response reports, and which write goes with it.
   typedef enum logic [1:0] {
      RES_NONE = 2'd0,
      RES_HIT  = 2'd1,
      RES_UPD  = 2'd2,
      RES_NEW  = 2'd3
   } res_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic       load_req;
      logic       scan_key;
      logic       scan_max;
      logic       shift_start;
      logic       shift_en;
      logic       commit;
      logic       dec_count;
      res_type    res_sel;
      logic [2:0] res_status;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic [2:0] op;
      logic       hit;
      logic       scan_done;
      logic       full;
      logic       empty;
      logic       out_busy;
   } sts_type;

endpackage

@@ hdl/krt_dpath.sv @@
// Datapath of the keyed record table: record memory, scan counters, capture and response.
module krt_dpath
   import krt_pkg::*;
#(
   parameter int CAPACITY = 64
) (
   input  logic        clock,
   input  logic        reset,
   input  cmd_type     cmd,
   output sts_type     sts,
   input  logic [2:0]  req_tuser,   // operation
   input  logic [71:0] req_tdata,   // key, attribute, amount
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [2:0]  rsp_tuser,   // status
   output logic [87:0] rsp_tdata    // position, found_key, found_attribute,
                                    // found_amount, entries_used, zero pad
);

   localparam int IDX_W = $clog2(CAPACITY);
   localparam int CNT_W = $clog2(CAPACITY + 1);

   rec_type rec_mem_ff [CAPACITY];

   logic [2:0]       op_ff;
   rec_type          req_ff;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [CNT_W-1:0] rd_idx_ff, rd_idx_in;
   logic             rd_valid_ff, rd_valid_in;
   logic [IDX_W-1:0] rd_addr_ff;
   rec_type          rd_data_ff;
   rec_type          cap_ff;
   logic [IDX_W-1:0] cap_idx_ff;
   logic             cap_set_ff, cap_set_in;

   logic             rsp_valid_ff, rsp_valid_in;
   logic [2:0]       rsp_status_ff;
   logic [5:0]       rsp_pos_ff;
   rec_type          rsp_rec_ff;
   logic [6:0]       rsp_used_ff;

   logic             issue;
   logic [IDX_W-1:0] rd_addr;
   logic             hit_key;
   logic             better;
   logic             capture;
   logic             wr_en;
   logic [IDX_W-1:0] wr_addr;
   rec_type          wr_data;
   rec_type          upd_rec;
   logic             out_busy;

   assign rd_addr  = rd_idx_ff[IDX_W-1:0];
   assign issue    = (cmd.scan_key || cmd.scan_max || cmd.shift_en) && (rd_idx_ff < count_ff);
   assign hit_key  = rd_valid_ff && (rd_data_ff.key == req_ff.key);
   assign better   = rd_valid_ff && (!cap_set_ff || (rd_data_ff.amount > cap_ff.amount));
   assign capture  = (cmd.scan_key && hit_key) || (cmd.scan_max && better);
   assign out_busy = rsp_valid_ff && !rsp_tready;

   assign upd_rec.key       = cap_ff.key;
   assign upd_rec.attribute = cap_ff.attribute;
   assign upd_rec.amount    = req_ff.amount;

   always_comb begin
      rd_idx_in = rd_idx_ff;
      if (cmd.load_req) begin
         rd_idx_in = '0;
      end else if (cmd.shift_start) begin
         rd_idx_in = CNT_W'(cap_idx_ff) + CNT_W'(1);
      end else if (issue) begin
         rd_idx_in = rd_idx_ff + CNT_W'(1);
      end
      rd_valid_in = issue;
   end

   always_comb begin
      cap_set_in = cap_set_ff;
      if (cmd.load_req) begin
         cap_set_in = 1'b0;
      end else if (capture) begin
         cap_set_in = 1'b1;
      end
   end

   // One write port: shifting during delete, or the commit of insert/update.
   always_comb begin
      wr_en   = 1'b0;
      wr_addr = rd_addr_ff - IDX_W'(1);
      wr_data = rd_data_ff;
      if (cmd.shift_en && rd_valid_ff) begin
         wr_en = 1'b1;
      end else if (cmd.commit && (cmd.res_sel == RES_NEW)) begin
         wr_en   = 1'b1;
         wr_addr = count_ff[IDX_W-1:0];
         wr_data = req_ff;
      end else if (cmd.commit && (cmd.res_sel == RES_UPD)) begin
         wr_en   = 1'b1;
         wr_addr = cap_idx_ff;
         wr_data = upd_rec;
      end
   end

   always_comb begin
      count_in = count_ff;
      if (cmd.commit && (cmd.res_sel == RES_NEW)) begin
         count_in = count_ff + CNT_W'(1);
      end else if (cmd.commit && cmd.dec_count) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.commit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         rec_mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= rec_mem_ff[rd_addr];
      rd_addr_ff <= rd_addr;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rd_idx_ff    <= '0;
         rd_valid_ff  <= 1'b0;
         cap_set_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rd_idx_ff    <= rd_idx_in;
         rd_valid_ff  <= rd_valid_in;
         cap_set_ff   <= cap_set_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         op_ff            <= req_tuser;
         req_ff.key       <= req_tdata[31:0];
         req_ff.attribute <= req_tdata[39:32];
         req_ff.amount    <= req_tdata[71:40];
      end
      if (capture) begin
         cap_ff     <= rd_data_ff;
         cap_idx_ff <= rd_addr_ff;
      end
      if (cmd.commit) begin
         rsp_status_ff <= cmd.res_status;
         rsp_used_ff   <= 7'(count_in);
         case (cmd.res_sel)
            RES_HIT: begin
               rsp_pos_ff <= 6'(cap_idx_ff);
               rsp_rec_ff <= cap_ff;
            end
            RES_UPD: begin
               rsp_pos_ff <= 6'(cap_idx_ff);
               rsp_rec_ff <= upd_rec;
            end
            RES_NEW: begin
               rsp_pos_ff <= 6'(count_ff[IDX_W-1:0]);
               rsp_rec_ff <= req_ff;
            end
            default: begin
               rsp_pos_ff <= '0;
               rsp_rec_ff <= '0;
            end
         endcase
      end
   end

   assign sts.op        = op_ff;
   assign sts.hit       = hit_key;
   assign sts.scan_done = (rd_idx_ff >= count_ff) && !rd_valid_ff;
   assign sts.full      = (count_ff == CNT_W'(CAPACITY));
   assign sts.empty     = (count_ff == '0);
   assign sts.out_busy  = out_busy;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tdata  = {3'b000, rsp_used_ff, rsp_rec_ff.amount, rsp_rec_ff.attribute,
                        rsp_rec_ff.key, rsp_pos_ff};

endmodule

@@ hdl/krt_ctrl.sv @@
// Controller state machine of the keyed record table.
module krt_ctrl
   import krt_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_tvalid,
   output logic    req_tready,
   output cmd_type cmd,
   input  sts_type sts
);

   typedef enum logic [5:0] {
      S_IDLE      = 6'b000001,
      S_DECODE    = 6'b000010,
      S_SCAN      = 6'b000100,
      S_SHIFT_SET = 6'b001000,
      S_SHIFT     = 6'b010000,
      S_FINISH    = 6'b100000
   } state_type;

   state_type  state_ff, state_in;
   res_type    res_sel_ff, res_sel_in;
   logic [2:0] res_status_ff, res_status_in;
   logic       dec_ff, dec_in;
   logic       is_max;

   assign is_max = (sts.op == OP_FINDMAX);

   always_comb begin
      state_in      = state_ff;
      res_sel_in    = res_sel_ff;
      res_status_in = res_status_ff;
      dec_in        = dec_ff;
      case (state_ff)
         S_IDLE: begin
            dec_in = 1'b0;
            if (req_tvalid) begin
               state_in = S_DECODE;
            end
         end
         S_DECODE: begin
            case (sts.op)
               OP_INSERT: begin
                  if (sts.full) begin
                     res_sel_in    = RES_NONE;
                     res_status_in = ST_FULL;
                     state_in      = S_FINISH;
                  end else begin
                     state_in = S_SCAN;
                  end
               end
               OP_LOOKUP, OP_UPDATE, OP_DELETE: begin
                  state_in = S_SCAN;
               end
               OP_FINDMAX: begin
                  if (sts.empty) begin
                     res_sel_in    = RES_NONE;
                     res_status_in = ST_EMPTY;
                     state_in      = S_FINISH;
                  end else begin
                     state_in = S_SCAN;
                  end
               end
               default: begin
                  res_sel_in    = RES_NONE;
                  res_status_in = ST_MISSING;
                  state_in      = S_FINISH;
               end
            endcase
         end
         S_SCAN: begin
            if (is_max) begin
               if (sts.scan_done) begin
                  res_sel_in    = RES_HIT;
                  res_status_in = ST_OK;
                  state_in      = S_FINISH;
               end
            end else if (sts.hit) begin
               res_status_in = ST_OK;
               res_sel_in    = RES_HIT;
               state_in      = S_FINISH;
               case (sts.op)
                  OP_INSERT: res_status_in = ST_DUP;
                  OP_UPDATE: res_sel_in = RES_UPD;
                  OP_DELETE: state_in = S_SHIFT_SET;
                  default:   res_sel_in = RES_HIT;
               endcase
            end else if (sts.scan_done) begin
               state_in = S_FINISH;
               if (sts.op == OP_INSERT) begin
                  res_sel_in    = RES_NEW;
                  res_status_in = ST_OK;
               end else begin
                  res_sel_in    = RES_NONE;
                  res_status_in = ST_MISSING;
               end
            end
         end
         S_SHIFT_SET: begin
            state_in = S_SHIFT;
         end
         S_SHIFT: begin
            if (sts.scan_done) begin
               dec_in   = 1'b1;
               state_in = S_FINISH;
            end
         end
         S_FINISH: begin
            if (!sts.out_busy) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      res_sel_ff    <= res_sel_in;
      res_status_ff <= res_status_in;
      dec_ff        <= dec_in;
   end

   assign req_tready      = (state_ff == S_IDLE);
   assign cmd.load_req    = req_tvalid && (state_ff == S_IDLE);
   assign cmd.scan_key    = (state_ff == S_SCAN) && !is_max;
   assign cmd.scan_max    = (state_ff == S_SCAN) && is_max;
   assign cmd.shift_start = (state_ff == S_SHIFT_SET);
   assign cmd.shift_en    = (state_ff == S_SHIFT);
   assign cmd.commit      = (state_ff == S_FINISH) && !sts.out_busy;
   assign cmd.dec_count   = dec_ff;
   assign cmd.res_sel     = res_sel_ff;
   assign cmd.res_status  = res_status_ff;

endmodule

@@ hdl/keyed_record_table_top.sv @@
// Top level of the keyed record table: controller, datapath and checks.
//
// The keyed record table holds up to CAPACITY records, each a unique signed
// 32-bit key, an 8-bit attribute and a 32-bit amount in cents, packed densely
// from index 0 in a memory with one read port and one write port. Each request
// (operation in req_tuser) inserts, looks up, updates, deletes or finds the
// record with the largest amount, and produces exactly one response whose
// status travels in rsp_tuser.
// Records are searched linearly from index 0 and deletion shifts the later
// records down by one. A full-table insert, a find on an empty table or an
// unknown operation is answered without a scan; the time of any other request
// depends on the number of stored records, since the record memory delivers
// one record per cycle to the comparator and, during deletion, moves one
// record per cycle. The response sits in an output register, so a new request
// is taken as soon as the controller is idle, even while the previous
// response waits to be accepted. The memory needs no clearing after reset:
// only records below the current count are ever read.
module keyed_record_table_top
   import krt_pkg::*;
#(
   parameter int CAPACITY = 64
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [2:0]  req_tuser,   // operation
   input  logic [71:0] req_tdata,   // key [31:0], attribute [39:32], amount [71:40]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [2:0]  rsp_tuser,   // status
   output logic [87:0] rsp_tdata    // position [5:0], found_key [37:6],
                                    // found_attribute [45:38], found_amount [77:46],
                                    // entries_used [84:78], zero [87:85]
);

   cmd_type cmd;
   sts_type sts;

   // The controller sequences each request through decode, the scan unless decode
   // settles it, the optional delete shift and the final commit of the response.
   krt_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .cmd        (cmd),
      .sts        (sts)
   );

   // The datapath owns the record memory, the entry count and the response.
   krt_dpath #(
      .CAPACITY (CAPACITY)
   ) u_dpath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .sts        (sts),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tuser  (rsp_tuser),
      .rsp_tdata  (rsp_tdata)
   );

`ifndef SYNTHESIS
   // A response is never committed over one that is still waiting.
   a_commit_free: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |-> !sts.out_busy)
      else $error("response committed while output register was busy");

   // An accepted request passes through decode before its response is committed.
   a_no_instant_rsp: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !cmd.commit)
      else $error("response committed directly after request acceptance");

   // Responses that report no record carry zero record fields.
   a_none_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && (rsp_tuser != ST_OK) && (rsp_tuser != ST_DUP))
         |-> (rsp_tdata[77:0] == 78'd0))
      else $error("record fields not zero on a status without a record");

   // Scan and shift commands never overlap.
   a_one_walk: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.scan_key, cmd.scan_max, cmd.shift_en, cmd.shift_start}))
      else $error("overlapping memory walk commands");
`endif

endmodule
